/* hdl/mvspm_pkg.sv */
package mvspm_pkg;

	// Field widths of one input transaction, one result, the register port and the voice state.
	localparam int ACTION_W   = 3;
	localparam int VOICE_W    = 3;
	localparam int ADDR_W     = 16;
	localparam int WORD_W     = 16;
	localparam int LENGTH_W   = 17;
	localparam int STEP_W     = 20;
	localparam int PEAK_W     = 15;
	localparam int GAIN_W     = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int POS_W      = 18;
	localparam int FRAC_W     = 16;

	// Defaults of the top-level parameters.
	localparam int DEF_VOICE_COUNT  = 5;
	localparam int DEF_MEMORY_WORDS = 65536;

	// Action codes.
	localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_TRIG  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_PEAK  = 3'd4;

	// Voice code that selects the master peak on a peak read.
	localparam logic [VOICE_W-1:0] MASTER_SELECT = 3'd5;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_LAST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER    = 3'd5;

	// Reset gains, Q8.
	localparam logic [GAIN_W-1:0] GAIN_RESET       = 9'd160;
	localparam logic [GAIN_W-1:0] GAIN_UNITY       = 9'd256;
	localparam int                UNITY_GAIN_VOICE = 4;

	// Result kinds.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_PEAK   = 1'b1;

	localparam logic [PEAK_W-1:0] PEAK_MAX = 15'h7FFF;

endpackage

/* hdl/mvspm_item_if.sv */
interface mvspm_item_if;
	import mvspm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic [VOICE_W-1:0]         voice;
	logic [ADDR_W-1:0]          address;
	logic signed [WORD_W-1:0]   sample_word;
	logic [LENGTH_W-1:0]        length;
	logic [STEP_W-1:0]          step;
	modport source (output valid, action, voice, address, sample_word, length, step,
		input ready);
	modport sink (input valid, action, voice, address, sample_word, length, step,
		output ready);
endinterface

/* hdl/mvspm_result_if.sv */
interface mvspm_result_if;
	import mvspm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       result_kind;
	logic signed [WORD_W-1:0]   out_sample;
	logic [PEAK_W-1:0]          peak_level;
	modport source (output valid, result_kind, out_sample, peak_level, input ready);
	modport sink (input valid, result_kind, out_sample, peak_level, output ready);
endinterface

/* hdl/mvspm_cfg_if.sv */
interface mvspm_cfg_if;
	import mvspm_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [GAIN_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/multi_voice_sample_playback_mixer_core.sv */
// Channel   Direction  Contents
// item      in         action, voice, address, sample_word, length, step
// result    out        result_kind, out_sample, peak_level
// cfg       in         index, data (Q8 voice gains 0..4, master gain 5)
//
// Memory writes, triggers and stop are done while idle; a peak read loads the
// output register. A tick works the voices in turn, an active one through
// S_VOICE, S_RD0, S_RD1, S_INT, S_GAIN and S_UPD, an idle one in S_VOICE only,
// then the master stage in S_MIX; the one multiplier and memory port set this.
// arst_n clears all voice state and peaks and restores the reset gains; the
// sample memory is not cleared. A result waits in the output register while
// result.ready is low, and no new transaction is taken until it leaves.
// MEMORY_WORDS must be a power of two, as addresses wrap at the memory size.
module multi_voice_sample_playback_mixer_core #(
	parameter int VOICE_COUNT  = mvspm_pkg::DEF_VOICE_COUNT,
	parameter int MEMORY_WORDS = mvspm_pkg::DEF_MEMORY_WORDS
) (
	input  logic            clk,
	input  logic            arst_n,
	mvspm_item_if.sink      item,
	mvspm_result_if.source  result,
	mvspm_cfg_if.sink       cfg
);
	import mvspm_pkg::*;

	localparam int AW     = $clog2(MEMORY_WORDS);
	localparam int IW     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CW     = $clog2(VOICE_COUNT + 1);
	localparam int ACC_W  = 18 + $clog2(VOICE_COUNT);
	localparam int MA     = ACC_W;
	localparam int MP     = MA + 16;

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_VOICE = 3'd1;
	localparam logic [2:0] S_RD0   = 3'd2;
	localparam logic [2:0] S_RD1   = 3'd3;
	localparam logic [2:0] S_INT   = 3'd4;
	localparam logic [2:0] S_GAIN  = 3'd5;
	localparam logic [2:0] S_UPD   = 3'd6;
	localparam logic [2:0] S_MIX   = 3'd7;

	logic [2:0] state_q;
	logic       out_stage_q;      // master product is in mul_q, output next
	logic [CW-1:0] v_q;
	logic [IW-1:0] vi;

	// Per-voice state.
	logic                  active_q [VOICE_COUNT];
	logic [ADDR_W-1:0]     start_q  [VOICE_COUNT];
	logic [LENGTH_W-1:0]   len_q    [VOICE_COUNT];
	logic [POS_W-1:0]      pos_q    [VOICE_COUNT];
	logic [FRAC_W-1:0]     frac_q   [VOICE_COUNT];
	logic [STEP_W-1:0]     step_q   [VOICE_COUNT];
	logic [PEAK_W-1:0]     vpeak_q  [VOICE_COUNT];
	logic [GAIN_W-1:0]     gain_q   [VOICE_COUNT];
	logic [PEAK_W-1:0]     mpeak_q;
	logic [GAIN_W-1:0]     mgain_q;

	// Datapath registers.
	logic signed [WORD_W-1:0] s_q;
	logic signed [16:0]       interp_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [MP-1:0]     mul_q;

	logic out_valid_q;
	logic out_kind_q;
	logic signed [WORD_W-1:0] out_sample_q;
	logic [PEAK_W-1:0]        out_peak_q;

	// Sample memory port.
	logic                     ram_we;
	logic [AW-1:0]            ram_addr;
	logic signed [WORD_W-1:0] ram_rdata;

	logic in_acc;
	logic [IW-1:0] in_vi;
	logic in_voice_ok;

	assign vi          = v_q[IW-1:0];
	assign in_vi       = IW'(item.voice);
	assign in_voice_ok = (32'(item.voice) < VOICE_COUNT);

	// A new transaction is taken only when idle and the output register is free.
	assign item.ready = (state_q == S_IDLE) && !out_stage_q && (!out_valid_q || result.ready);
	assign in_acc     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.out_sample  = out_sample_q;
	assign result.peak_level  = out_peak_q;

	// Addresses of the current and the following word of the voice.
	logic [18:0] rd_base;
	logic        has_next;
	assign rd_base  = {3'b000, start_q[vi]} + {1'b0, pos_q[vi]};
	assign has_next = ({1'b0, pos_q[vi]} + 19'd1) < {2'b00, len_q[vi]};

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = AW'(rd_base);
		if (state_q == S_IDLE) begin
			ram_we   = in_acc && (item.action == ACT_WRITE);
			ram_addr = AW'(item.address);
		end else if (state_q == S_RD0) begin
			ram_addr = AW'(rd_base + 19'd1);
		end
	end

	mvspm_sample_ram #(
		.MEMORY_WORDS(MEMORY_WORDS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(item.sample_word),
		.rdata_q(ram_rdata)
	);

	// The one shared multiplier; its operands follow the sequencer state.
	logic signed [WORD_W-1:0] nx;
	logic signed [16:0]       diff;
	logic signed [MA-1:0]     mul_a;
	logic signed [15:0]       mul_b;
	logic signed [MP-1:0]     prod;

	assign nx   = has_next ? ram_rdata : '0;
	assign diff = {nx[WORD_W-1], nx} - {s_q[WORD_W-1], s_q};

	always_comb begin
		mul_a = MA'(diff);
		mul_b = $signed({1'b0, frac_q[vi][FRAC_W-1:1]});
		if (state_q == S_GAIN) begin
			mul_a = MA'(interp_q);
			mul_b = $signed({7'b0, gain_q[vi]});
		end else if (state_q == S_MIX) begin
			mul_a = acc_q;
			mul_b = $signed({7'b0, mgain_q});
		end
	end

	// The full-width product is formed in an assignment to the product width.
	assign prod = mul_a * mul_b;

	// Interpolation, voice gain and mix arithmetic after the multiplier.
	logic signed [MP-1:0] sh15, sh8;
	logic signed [16:0]   interp_n;
	logic signed [17:0]   g;
	logic [17:0]          mag;
	logic [PEAK_W-1:0]    mag_c;
	logic [20:0]          fsum;
	logic [18:0]          pos_n;
	logic signed [WORD_W-1:0] mix;
	logic [PEAK_W-1:0]    level;

	assign sh15     = mul_q >>> 15;
	assign sh8      = mul_q >>> 8;
	assign interp_n = {s_q[WORD_W-1], s_q} + sh15[16:0];
	assign g        = sh8[17:0];
	assign mag      = g[17] ? 18'(-g) : 18'(g);
	assign mag_c    = (mag > 18'(PEAK_MAX)) ? PEAK_MAX : mag[PEAK_W-1:0];
	assign fsum     = {5'b0, frac_q[vi]} + {1'b0, step_q[vi]};
	assign pos_n    = {1'b0, pos_q[vi]} + {14'b0, fsum[20:16]};

	always_comb begin
		if (sh8 > MP'(32767)) begin
			mix = 16'sh7FFF;
		end else if (sh8 < -MP'(32768)) begin
			mix = -16'sh8000;
		end else begin
			mix = sh8[WORD_W-1:0];
		end
	end
	assign level = mix[WORD_W-1] ? ~mix[PEAK_W-1:0] : mix[PEAK_W-1:0];

	// Sequencer and voice state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_stage_q  <= 1'b0;
			v_q          <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_SAMPLE;
			out_sample_q <= '0;
			out_peak_q   <= '0;
			s_q          <= '0;
			interp_q     <= '0;
			acc_q        <= '0;
			mul_q        <= '0;
			mpeak_q      <= '0;
			mgain_q      <= GAIN_UNITY;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				active_q[i] <= 1'b0;
				start_q[i]  <= '0;
				len_q[i]    <= '0;
				pos_q[i]    <= '0;
				frac_q[i]   <= '0;
				step_q[i]   <= '0;
				vpeak_q[i]  <= '0;
				gain_q[i]   <= (i == UNITY_GAIN_VOICE) ? GAIN_UNITY : GAIN_RESET;
			end
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid) begin
				if (cfg.index <= REG_GAIN_LAST) begin
					if (32'(cfg.index) < VOICE_COUNT) begin
						gain_q[IW'(cfg.index)] <= cfg.data;
					end
				end else if (cfg.index == REG_MASTER) begin
					mgain_q <= cfg.data;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (out_stage_q) begin
						out_stage_q  <= 1'b0;
						out_valid_q  <= 1'b1;
						out_kind_q   <= KIND_SAMPLE;
						out_sample_q <= mix;
						out_peak_q   <= '0;
						if (level > mpeak_q) begin
							mpeak_q <= level;
						end
					end else if (in_acc) begin
						case (item.action)
							ACT_TRIG: begin
								if (in_voice_ok) begin
									start_q[in_vi]  <= item.address;
									len_q[in_vi]    <= item.length;
									pos_q[in_vi]    <= '0;
									frac_q[in_vi]   <= '0;
									step_q[in_vi]   <= item.step;
									active_q[in_vi] <= (item.length != '0);
								end
							end
							ACT_STOP: begin
								for (int i = 0; i < VOICE_COUNT; i++) begin
									active_q[i] <= 1'b0;
								end
							end
							ACT_TICK: begin
								v_q     <= '0;
								acc_q   <= '0;
								state_q <= S_VOICE;
							end
							ACT_PEAK: begin
								out_valid_q  <= 1'b1;
								out_kind_q   <= KIND_PEAK;
								out_sample_q <= '0;
								if (in_voice_ok) begin
									out_peak_q     <= vpeak_q[in_vi];
									vpeak_q[in_vi] <= '0;
								end else if (item.voice == MASTER_SELECT) begin
									out_peak_q <= mpeak_q;
									mpeak_q    <= '0;
								end else begin
									out_peak_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_VOICE: begin
					if (32'(v_q) >= VOICE_COUNT) begin
						state_q <= S_MIX;
					end else if (!active_q[vi]) begin
						v_q <= v_q + CW'(1);
					end else begin
						state_q <= S_RD0;
					end
				end
				S_RD0: begin
					s_q     <= ram_rdata;
					state_q <= S_RD1;
				end
				S_RD1: begin
					mul_q   <= prod;
					state_q <= S_INT;
				end
				S_INT: begin
					interp_q <= interp_n;
					state_q  <= S_GAIN;
				end
				S_GAIN: begin
					mul_q   <= prod;
					state_q <= S_UPD;
				end
				S_UPD: begin
					acc_q      <= acc_q + ACC_W'(g);
					if (mag_c > vpeak_q[vi]) begin
						vpeak_q[vi] <= mag_c;
					end
					frac_q[vi] <= fsum[FRAC_W-1:0];
					pos_q[vi]  <= pos_n[POS_W-1:0];
					if (pos_n >= {2'b00, len_q[vi]}) begin
						active_q[vi] <= 1'b0;
					end
					v_q     <= v_q + CW'(1);
					state_q <= S_VOICE;
				end
				S_MIX: begin
					mul_q       <= prod;
					out_stage_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// The sample memory is written only by a write transaction taken while idle.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE) && item.valid && item.action == ACT_WRITE)
		else $error("sample memory written outside an idle write");

	// A new result appears only after a peak read or at the end of a tick.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(out_stage_q) ||
			$past(in_acc && item.action == ACT_PEAK))
		else $error("result without a tick or peak read");

	// A tick result never carries a peak level.
	a_tick_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_SAMPLE) |-> out_peak_q == '0)
		else $error("tick result with nonzero peak");

	// No transaction is taken while a tick is being worked.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !item.ready)
		else $error("ready during a tick");
`endif

endmodule

/* hdl/mvspm_sample_ram.sv */
module mvspm_sample_ram #(
	parameter int MEMORY_WORDS = mvspm_pkg::DEF_MEMORY_WORDS
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [$clog2(MEMORY_WORDS)-1:0]       addr,
	input  logic signed [mvspm_pkg::WORD_W-1:0]   wdata,
	output logic signed [mvspm_pkg::WORD_W-1:0]   rdata_q
);
	import mvspm_pkg::*;

	// Single port: one registered read per cycle, and a write to the same address when we is high.
	logic signed [WORD_W-1:0] mem [MEMORY_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

endmodule

/* tb/tb_multi_voice_sample_playback_mixer_core.sv */
`timescale 1ns / 100ps

module tb_multi_voice_sample_playback_mixer_core;
	import mvspm_pkg::*;

	localparam int NVOICE = DEF_VOICE_COUNT;
	localparam int WATCHDOG_LIMIT = 20000;
	// Memory region used by the random part; every word in it is written first.
	localparam int POOL_BASE = 16'hFF00;
	localparam int POOL_SIZE = 128;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VOICE_W-1:0]  voice;
		logic [ADDR_W-1:0]   address;
		logic [WORD_W-1:0]   sample_word;
		logic [LENGTH_W-1:0] length;
		logic [STEP_W-1:0]   step;
	} mixer_cmd_t;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] sample;
		logic [PEAK_W-1:0] peak;
	} mixer_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mvspm_item_if   item_ch();
	mvspm_result_if result_ch();
	mvspm_cfg_if    cfg_ch();

	multi_voice_sample_playback_mixer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source),
		.cfg    (cfg_ch.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state, mirrored from the block's architectural state.
	logic signed [15:0] mem_model [0:65535];
	logic               act_m [NVOICE];
	logic [15:0]        start_m [NVOICE];
	logic [16:0]        len_m [NVOICE];
	logic [17:0]        pos_m [NVOICE];
	logic [15:0]        frac_m [NVOICE];
	logic [19:0]        step_m [NVOICE];
	logic [14:0]        vpeak_m [NVOICE];
	logic [14:0]        mpeak_m;
	logic [8:0]         gain_m [NVOICE];
	logic [8:0]         master_m;

	mixer_cmd_t pending_cmds[$];
	mixer_out_t expected_outs[$];
	int         error_count = 0;
	logic       stimulus_done = 1'b0;
	logic       tb_pause = 1'b0;      // sender hold-off driven by the stimulus process
	int         sink_hold = 0;        // long receiver stall requested by stimulus
	logic       pool_ready = 1'b0;

	// Floor division by 2^n of a signed value: arithmetic shift does this directly.
	function automatic longint floor_div(input longint v, input int n);
		return v >>> n;
	endfunction

	// Apply one accepted command to the predictor and queue any result it causes.
	task automatic mix_predict(input mixer_cmd_t c);
		longint acc, s, nxt, g, mag, mix;
		logic [31:0] p, f;
		mixer_out_t r;
		acc = 0;
		case (c.action)
			ACT_WRITE: mem_model[c.address] = c.sample_word;
			ACT_TRIG: begin
				if (c.voice < NVOICE) begin
					start_m[c.voice] = c.address;
					len_m[c.voice] = c.length;
					pos_m[c.voice] = '0;
					frac_m[c.voice] = '0;
					step_m[c.voice] = c.step;
					act_m[c.voice] = (c.length != 0);
				end
			end
			ACT_STOP: for (int i = 0; i < NVOICE; i++) act_m[i] = 1'b0;
			ACT_TICK: begin
				for (int i = 0; i < NVOICE; i++) begin
					if (act_m[i]) begin
						p = pos_m[i];
						f = frac_m[i];
						s = mem_model[16'(start_m[i] + p)];
						nxt = (p + 1 < len_m[i]) ? longint'(mem_model[16'(start_m[i] + p + 1)]) : 0;
						s = s + floor_div((nxt - s) * longint'(f >> 1), 15);
						g = floor_div(s * longint'(gain_m[i]), 8);
						acc += g;
						mag = (g < 0) ? -g : g;
						if (mag > 32767) mag = 32767;
						if (mag > vpeak_m[i]) vpeak_m[i] = 15'(mag);
						f = f + step_m[i];
						p = p + (f >> 16);
						pos_m[i] = p[17:0];
						frac_m[i] = f[15:0];
						if (p >= len_m[i]) act_m[i] = 1'b0;
					end
				end
				mix = floor_div(acc * longint'(master_m), 8);
				if (mix > 32767) mix = 32767;
				if (mix < -32768) mix = -32768;
				mag = (mix < 0) ? -(mix + 1) : mix;
				if (mag > mpeak_m) mpeak_m = 15'(mag);
				r.kind = KIND_SAMPLE;
				r.sample = 16'(mix);
				r.peak = '0;
				expected_outs.push_back(r);
			end
			ACT_PEAK: begin
				r.kind = KIND_PEAK;
				r.sample = '0;
				r.peak = '0;
				if (c.voice < NVOICE) begin
					r.peak = vpeak_m[c.voice];
					vpeak_m[c.voice] = '0;
				end else if (c.voice == MASTER_SELECT) begin
					r.peak = mpeak_m;
					mpeak_m = '0;
				end
				expected_outs.push_back(r);
			end
			default: ;
		endcase
	endtask

	// Driver: one transaction at a time from the pending queue, with random gaps.
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.action <= '0;
			item_ch.voice <= '0;
			item_ch.address <= '0;
			item_ch.sample_word <= '0;
			item_ch.length <= '0;
			item_ch.step <= '0;
			src_gap <= 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				mix_predict({item_ch.action, item_ch.voice, item_ch.address,
					item_ch.sample_word, item_ch.length, item_ch.step});
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (src_gap > 0) begin
					item_ch.valid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (pending_cmds.size() > 0 && !tb_pause) begin
					mixer_cmd_t c;
					c = pending_cmds.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.action <= c.action;
					item_ch.voice <= c.voice;
					item_ch.address <= c.address;
					item_ch.sample_word <= c.sample_word;
					item_ch.length <= c.length;
					item_ch.step <= c.step;
					src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transaction against the oldest expectation.
	int sink_gap = 0;
	int hold_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			sink_gap <= 0;
			hold_left <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_outs.size() == 0) begin
					$display("%0t: unexpected result kind=%0d sample=%0d peak=%0d", $time,
						result_ch.result_kind, result_ch.out_sample, result_ch.peak_level);
					error_count++;
				end else begin
					mixer_out_t e;
					e = expected_outs.pop_front();
					if (e.kind !== result_ch.result_kind) begin
						$display("%0t: result_kind expected %0d actual %0d", $time,
							e.kind, result_ch.result_kind);
						error_count++;
					end
					if (e.sample !== result_ch.out_sample) begin
						$display("%0t: out_sample expected %0d actual %0d", $time,
							$signed(e.sample), result_ch.out_sample);
						error_count++;
					end
					if (e.peak !== result_ch.peak_level) begin
						$display("%0t: peak_level expected %0d actual %0d", $time,
							e.peak, result_ch.peak_level);
						error_count++;
					end
				end
			end
			// A long stall request takes priority over the per-transaction gaps.
			if (sink_hold > 0 && hold_left == 0 && !result_ch.ready) begin
				hold_left <= sink_hold;
				sink_hold = 0;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (sink_gap > 0) begin
				result_ch.ready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else begin
				result_ch.ready <= 1'b1;
				if (result_ch.valid && result_ch.ready)
					sink_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
			end
		end
	end

	// Watchdog: count cycles in which no transaction is accepted anywhere.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("multi_voice_sample_playback_mixer_core test failed");
			$finish;
		end
	end

	function automatic mixer_cmd_t make_cmd(input logic [2:0] a, input logic [2:0] v,
		input logic [15:0] ad, input logic [15:0] w, input logic [16:0] l,
		input logic [19:0] st);
		mixer_cmd_t c;
		c.action = a;
		c.voice = v;
		c.address = ad;
		c.sample_word = w;
		c.length = l;
		c.step = st;
		return c;
	endfunction

	// Random trigger that only reads inside the written pool.
	function automatic mixer_cmd_t pool_trigger(input int v);
		int len, st;
		st = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20'hFFFFF) : $urandom_range(0, 200000);
		len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
		return make_cmd(ACT_TRIG, 3'(v), 16'(POOL_BASE + $urandom_range(0, POOL_SIZE - 60)),
			16'($urandom), 17'(len), 20'(st));
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || item_ch.valid || expected_outs.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (idx <= REG_GAIN_LAST) gain_m[idx] = val;
		else if (idx == REG_MASTER) master_m = val;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int choice;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		for (int i = 0; i < NVOICE; i++) begin
			act_m[i] = 0; start_m[i] = 0; len_m[i] = 0; pos_m[i] = 0;
			frac_m[i] = 0; step_m[i] = 0; vpeak_m[i] = 0;
			gain_m[i] = (i == UNITY_GAIN_VOICE) ? GAIN_UNITY : GAIN_RESET;
		end
		mpeak_m = 0;
		master_m = GAIN_UNITY;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes, address wrap, stop, ignored voice and actions.
		pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 16'hFFFF, 16'h7FFF, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 16'h0000, 16'h8000, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 16'h0001, 16'h1234, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 16'h0002, 16'hEDCB, 0, 0));
		// Voice 0 wraps from the top of memory, voice 1 has the fastest step.
		pending_cmds.push_back(make_cmd(ACT_TRIG, 0, 16'hFFFF, 0, 3, 20'h08000));
		pending_cmds.push_back(make_cmd(ACT_TRIG, 1, 16'h0000, 0, 2, 20'hFFFFF));
		pending_cmds.push_back(make_cmd(ACT_TRIG, 2, 16'h0000, 0, 0, 20'h10000));
		pending_cmds.push_back(make_cmd(ACT_TRIG, 6, 16'h0000, 16'hFFFF, 17'h1FFFF, 20'h1));
		pending_cmds.push_back(make_cmd(ACT_TRIG, 4, 16'hFFFF, 0, 17'h10000, 20'h0));
		for (int i = 0; i < 4; i++) pending_cmds.push_back(make_cmd(ACT_TICK, 0, 0, 0, 0, 0));
		for (int v = 0; v < 8; v++) pending_cmds.push_back(make_cmd(ACT_PEAK, 3'(v), 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_STOP, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(ACT_TICK, 0, 0, 0, 0, 0));
		for (int a = 5; a < 8; a++)
			pending_cmds.push_back(make_cmd(3'(a), 3'($urandom), 16'($urandom), 16'($urandom),
				17'($urandom), 20'($urandom)));
		wait_drained();

		// Fill the pool region that all random triggers read from.
		for (int i = 0; i < POOL_SIZE; i++)
			pending_cmds.push_back(make_cmd(ACT_WRITE, 0, 16'(POOL_BASE + i), 16'($urandom), 0, 0));
		wait_drained();

		// Random phases under several gain settings, extremes among them.
		for (int phase = 0; phase < 4; phase++) begin
			for (int i = 0; i <= REG_MASTER; i++) begin
				case (phase)
					0: write_gain(3'(i), 9'd256);
					1: write_gain(3'(i), 9'd0);
					2: write_gain(3'(i), 9'h1FF);
					default: write_gain(3'(i), 9'($urandom_range(0, 256)));
				endcase
			end
			// Writes to register indexes that do not exist are ignored.
			write_gain(3'd6, 9'($urandom));
			write_gain(3'd7, 9'($urandom));
			for (int n = 0; n < 150; n++) begin
				choice = $urandom_range(0, 99);
				if (choice < 15)
					pending_cmds.push_back(pool_trigger($urandom_range(0, NVOICE - 1)));
				else if (choice < 70)
					pending_cmds.push_back(make_cmd(ACT_TICK, 3'($urandom), 16'($urandom),
						16'($urandom), 17'($urandom), 20'($urandom)));
				else if (choice < 80)
					pending_cmds.push_back(make_cmd(ACT_PEAK, 3'($urandom_range(0, 7)),
						16'($urandom), 16'($urandom), 17'($urandom), 20'($urandom)));
				else if (choice < 90)
					pending_cmds.push_back(make_cmd(ACT_WRITE, 3'($urandom),
						16'(POOL_BASE + $urandom_range(0, POOL_SIZE - 1)), 16'($urandom),
						17'($urandom), 20'($urandom)));
				else if (choice < 93)
					pending_cmds.push_back(make_cmd(ACT_STOP, 0, 0, 0, 0, 0));
				else if (choice < 96)
					pending_cmds.push_back(make_cmd(3'($urandom_range(5, 7)), 0, 0, 0, 0, 0));
				else
					pending_cmds.push_back(make_cmd(ACT_TRIG, 3'($urandom_range(5, 7)),
						16'($urandom), 0, 17'($urandom), 20'($urandom)));
				if (phase == 1 && n == 60) begin
					// Receiver stalls for a long time while items keep coming.
					sink_hold = 400;
				end
				if (phase == 2 && n == 100) begin
					// Sender waits here until every expected result is back.
					while (pending_cmds.size() > 0 || item_ch.valid) @(posedge clk);
					tb_pause <= 1'b1;
					while (expected_outs.size() > 0) @(posedge clk);
					tb_pause <= 1'b0;
				end
			end
			wait_drained();
		end
		stimulus_done = 1'b1;

		if (error_count == 0)
			$display("multi_voice_sample_playback_mixer_core test passed");
		else
			$display("multi_voice_sample_playback_mixer_core test failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/mvspm_pkg.sv
hdl/mvspm_item_if.sv
hdl/mvspm_result_if.sv
hdl/mvspm_cfg_if.sv
hdl/mvspm_sample_ram.sv
hdl/multi_voice_sample_playback_mixer_core.sv
tb/tb_multi_voice_sample_playback_mixer_core.sv
